// File: src/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg - shared definitions for the first-fit block allocator
// Status codes, register indexes, field widths and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  localparam int unsigned DefMaxBlocks   = 16;
  localparam int unsigned DefHeaderBytes = 24;

  localparam int unsigned AddrW = 32;
  localparam int unsigned SizeW = 24;
  localparam int unsigned NeedW = SizeW + 1;

  localparam logic [AddrW-1:0] ResetHeapBase  = '0;
  localparam logic [SizeW-1:0] ResetHeapBytes = 24'd1048576;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OUT_OF_MEM = 3'd1,
    ST_ZERO_SIZE  = 3'd2,
    ST_DBL_FREE   = 3'd3,
    ST_BAD_ADDR   = 3'd4
  } status_e;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_BYTES = 1'b1
  } reg_idx_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_ALLOC = 7'b0000100,
    S_FREE  = 7'b0001000,
    S_MR    = 7'b0010000,
    S_ML    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

// File: src/first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top - first-fit heap allocator with coalescing
// Keeps an address-ordered table of heap blocks and serves allocate and free
// requests one item at a time, with running usage statistics.
// ----------------------------------------------------------------------------
// The scan reads one table entry a cycle and covers at most MAX_BLOCKS
// entries; a zero-size allocate or a null free skips the scan. No new item
// is taken until the result of the last one sits in the output register.
// Reset (async, active low) builds one free block covering the default heap.
`default_nettype none

module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = fba_pkg::DefMaxBlocks,
  parameter int unsigned HEADER_BYTES = fba_pkg::DefHeaderBytes,
  localparam int unsigned IW = $clog2(MAX_BLOCKS),
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [fba_pkg::AddrW-1:0] cfg_data_i,
  // request channel
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      func_i,
  input  wire logic [fba_pkg::SizeW-1:0] request_bytes_i,
  input  wire logic [fba_pkg::AddrW-1:0] release_address_i,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2:0]                     status_o,
  output logic [fba_pkg::AddrW-1:0]      payload_address_o,
  output logic [fba_pkg::SizeW-1:0]      total_bytes_o,
  output logic [fba_pkg::SizeW-1:0]      used_bytes_o,
  output logic [fba_pkg::SizeW-1:0]      free_bytes_o,
  output logic [CW-1:0]                  block_count_o
);

  localparam int unsigned SW = fba_pkg::SizeW;
  localparam int unsigned AW = fba_pkg::AddrW;
  localparam int unsigned NW = fba_pkg::NeedW;

  // Header size seen at the three widths it is used at.
  localparam logic [NW-1:0] HdrN = NW'(HEADER_BYTES);
  localparam logic [SW-1:0] HdrS = SW'(HEADER_BYTES);
  localparam logic [AW-1:0] HdrA = AW'(HEADER_BYTES);
  localparam logic [SW-1:0] SplitMin = SW'(HEADER_BYTES + 8);

  // Block table: one size and one free mark per entry, zero past the count.
  logic [SW-1:0] size_q [MAX_BLOCKS];
  logic [SW-1:0] size_d [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] free_q, free_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] used_q, used_d, ftot_q, ftot_d;

  logic [AW-1:0] base_q, base_d;
  logic [SW-1:0] hbytes_q, hbytes_d;

  // Sequencer and per-item working registers.
  fba_pkg::state_e state_q, state_d;
  logic          func_q, func_d;
  logic [NW-1:0] need_q, need_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [SW-1:0] off_q, off_d;
  logic [SW-1:0] tmp_q, tmp_d;
  logic [2:0]    stat_q, stat_d;
  logic [AW-1:0] addr_q, addr_d;

  // Output register.
  logic          ovld_q, ovld_d;
  logic [2:0]    ostat_q, ostat_d;
  logic [AW-1:0] oaddr_q, oaddr_d;
  logic [SW-1:0] ototal_q, ototal_d, oused_q, oused_d, ofree_q, ofree_d;
  logic [CW-1:0] ocount_q, ocount_d;

  // Shared datapath around the entry under the scan pointer.
  logic [IW-1:0] idx_w, idx1_w;
  logic [SW-1:0] cur_size, rest, taken, new_bytes;
  logic          cur_free, in_range, split;
  logic [AW-1:0] cur_addr;

  assign idx_w    = idx_q[IW-1:0];
  assign idx1_w   = IW'(idx_q + CW'(1));
  assign cur_size = size_q[idx_w];
  assign cur_free = free_q[idx_w];
  assign in_range = (idx_q < count_q);
  assign cur_addr = base_q + {{(AW-SW){1'b0}}, off_q} + HdrA;
  assign rest     = cur_size - need_q[SW-1:0];
  assign split    = (rest > SplitMin) && (count_q < CW'(MAX_BLOCKS));
  assign taken    = split ? need_q[SW-1:0] : cur_size;

  assign in_ready_o  = (state_q == fba_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    size_d   = size_q;
    free_d   = free_q;
    count_d  = count_q;
    used_d   = used_q;
    ftot_d   = ftot_q;
    base_d   = base_q;
    hbytes_d = hbytes_q;
    state_d  = state_q;
    func_d   = func_q;
    need_d   = need_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    off_d    = off_q;
    tmp_d    = tmp_q;
    stat_d   = stat_q;
    addr_d   = addr_q;
    ovld_d   = ovld_q;
    ostat_d  = ostat_q;
    oaddr_d  = oaddr_q;
    ototal_d = ototal_q;
    oused_d  = oused_q;
    ofree_d  = ofree_q;
    ocount_d = ocount_q;
    new_bytes = hbytes_q;

    // drop the result once taken
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      fba_pkg::S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          ptr_d  = release_address_i;
          idx_d  = '0;
          off_d  = '0;
          addr_d = '0;
          stat_d = fba_pkg::ST_OK;
          // round request plus header up to a multiple of 8 bytes
          need_d = (NW'(request_bytes_i) + HdrN + NW'(7)) & ~NW'(7);
          if (func_i == fba_pkg::FUNC_ALLOC) begin
            if (request_bytes_i == '0) begin
              stat_d  = fba_pkg::ST_ZERO_SIZE;
              state_d = fba_pkg::S_DONE;
            end else begin
              state_d = fba_pkg::S_SCAN;
            end
          end else if (release_address_i == '0) begin
            stat_d  = fba_pkg::ST_BAD_ADDR;
            state_d = fba_pkg::S_DONE;
          end else begin
            state_d = fba_pkg::S_SCAN;
          end
        end
      end

      fba_pkg::S_SCAN: begin
        if (!in_range) begin
          stat_d  = (func_q == fba_pkg::FUNC_ALLOC) ? fba_pkg::ST_OUT_OF_MEM
                                                    : fba_pkg::ST_BAD_ADDR;
          state_d = fba_pkg::S_DONE;
        end else if (func_q == fba_pkg::FUNC_ALLOC &&
                     cur_free && ({1'b0, cur_size} >= need_q)) begin
          state_d = fba_pkg::S_ALLOC;
        end else if (func_q == fba_pkg::FUNC_FREE && cur_addr == ptr_q) begin
          state_d = fba_pkg::S_FREE;
        end else begin
          // advance to the next block
          off_d = off_q + cur_size;
          idx_d = idx_q + CW'(1);
        end
      end

      fba_pkg::S_ALLOC: begin
        if (split) begin
          // open a slot right after the chosen block
          for (int k = 1; k < MAX_BLOCKS; k++) begin
            if (CW'(k) > idx_q + CW'(1)) begin
              size_d[k] = size_q[k-1];
              free_d[k] = free_q[k-1];
            end
          end
          size_d[idx_w]  = need_q[SW-1:0];
          size_d[idx1_w] = rest;
          free_d[idx1_w] = 1'b1;
          count_d        = count_q + CW'(1);
        end
        free_d[idx_w] = 1'b0;
        used_d  = used_q + taken;
        ftot_d  = ftot_q - taken;
        addr_d  = cur_addr;
        state_d = fba_pkg::S_DONE;
      end

      fba_pkg::S_FREE: begin
        if (cur_free) begin
          stat_d  = fba_pkg::ST_DBL_FREE;
          state_d = fba_pkg::S_DONE;
        end else begin
          free_d[idx_w] = 1'b1;
          used_d  = used_q - cur_size;
          ftot_d  = ftot_q + cur_size;
          tmp_d   = cur_size;
          pos_d   = idx_q;
          idx_d   = idx_q + CW'(1);
          state_d = fba_pkg::S_MR;
        end
      end

      fba_pkg::S_MR: begin
        // merge the right neighbor into the freed block
        if (in_range && cur_free) begin
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (CW'(k) >= idx_q) begin
              size_d[k] = (k < MAX_BLOCKS - 1) ? size_q[(k+1) % MAX_BLOCKS] : '0;
              free_d[k] = (k < MAX_BLOCKS - 1) ? free_q[(k+1) % MAX_BLOCKS] : 1'b0;
            end
          end
          size_d[pos_q[IW-1:0]] = tmp_q + cur_size;
          tmp_d   = tmp_q + cur_size;
          count_d = count_q - CW'(1);
        end
        if (pos_q != '0) begin
          idx_d   = pos_q - CW'(1);
          state_d = fba_pkg::S_ML;
        end else begin
          state_d = fba_pkg::S_DONE;
        end
      end

      fba_pkg::S_ML: begin
        // merge the freed block into a free left neighbor
        if (cur_free) begin
          for (int k = 0; k < MAX_BLOCKS; k++) begin
            if (CW'(k) > idx_q) begin
              size_d[k] = (k < MAX_BLOCKS - 1) ? size_q[(k+1) % MAX_BLOCKS] : '0;
              free_d[k] = (k < MAX_BLOCKS - 1) ? free_q[(k+1) % MAX_BLOCKS] : 1'b0;
            end
          end
          size_d[idx_w] = cur_size + tmp_q;
          count_d = count_q - CW'(1);
        end
        state_d = fba_pkg::S_DONE;
      end

      fba_pkg::S_DONE: begin
        // hold until the output register is free
        if (!ovld_q || out_ready_i) begin
          ovld_d   = 1'b1;
          ostat_d  = stat_q;
          oaddr_d  = addr_q;
          ototal_d = used_q + ftot_q;
          oused_d  = used_q;
          ofree_d  = ftot_q;
          ocount_d = count_q;
          state_d  = fba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = fba_pkg::S_IDLE;
      end
    endcase

    // A register write rebuilds the table; the user must write only while idle, the block does not enforce it.
    if (cfg_valid_i) begin
      if (cfg_index_i == fba_pkg::REG_HEAP_BASE) begin
        base_d = cfg_data_i;
      end else begin
        hbytes_d  = cfg_data_i[SW-1:0];
        new_bytes = cfg_data_i[SW-1:0];
      end
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        size_d[k] = '0;
      end
      free_d = '0;
      used_d = '0;
      if (new_bytes >= HdrS) begin
        size_d[0] = new_bytes;
        free_d[0] = 1'b1;
        count_d   = CW'(1);
        ftot_d    = new_bytes;
      end else begin
        count_d = '0;
        ftot_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        size_q[k] <= (k == 0) ? fba_pkg::ResetHeapBytes : '0;
      end
      free_q   <= MAX_BLOCKS'(1);
      count_q  <= CW'(1);
      used_q   <= '0;
      ftot_q   <= fba_pkg::ResetHeapBytes;
      base_q   <= fba_pkg::ResetHeapBase;
      hbytes_q <= fba_pkg::ResetHeapBytes;
      state_q  <= fba_pkg::S_IDLE;
      ovld_q   <= 1'b0;
    end else begin
      size_q   <= size_d;
      free_q   <= free_d;
      count_q  <= count_d;
      used_q   <= used_d;
      ftot_q   <= ftot_d;
      base_q   <= base_d;
      hbytes_q <= hbytes_d;
      state_q  <= state_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    need_q   <= need_d;
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    off_q    <= off_d;
    tmp_q    <= tmp_d;
    stat_q   <= stat_d;
    addr_q   <= addr_d;
    ostat_q  <= ostat_d;
    oaddr_q  <= oaddr_d;
    ototal_q <= ototal_d;
    oused_q  <= oused_d;
    ofree_q  <= ofree_d;
    ocount_q <= ocount_d;
  end

  assign out_valid_o       = ovld_q;
  assign status_o          = ostat_q;
  assign payload_address_o = oaddr_q;
  assign total_bytes_o     = ototal_q;
  assign used_bytes_o      = oused_q;
  assign free_bytes_o      = ofree_q;
  assign block_count_o     = ocount_q;

endmodule

`default_nettype wire
